/* src/mfd_pkg.sv */
// ----------------------------------------------------------------------------
// mfd_pkg
// shared types, constants and helpers of the multipart form deframer
// ----------------------------------------------------------------------------
package mfd_pkg;

	localparam int MaxBoundary = 56;
	localparam int WinDepth    = MaxBoundary + 4;
	localparam int FillW       = $clog2(WinDepth + 1);
	localparam int PrefixLen   = 31;
	localparam int PrefixDead  = 32;
	localparam int NeedleLen   = 10;
	localparam int NumRegs     = 8;

	typedef enum logic [2:0] {
		PH_OPEN = 3'd0,
		PH_HEAD = 3'd1,
		PH_DATA = 3'd2,
		PH_DONE = 3'd3,
		PH_FAIL = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		KIND_FILE_BYTE  = 3'd0,
		KIND_NAME_CHAR  = 3'd1,
		KIND_NAME_DONE  = 3'd2,
		KIND_UPLOAD_END = 3'd3,
		KIND_BAD_OPEN   = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		REG_LENGTH = 3'd0,
		REG_WORD0  = 3'd1,
		REG_WORD1  = 3'd2,
		REG_WORD2  = 3'd3,
		REG_WORD3  = 3'd4,
		REG_WORD4  = 3'd5,
		REG_WORD5  = 3'd6,
		REG_WORD6  = 3'd7
	} reg_idx_t;

	localparam logic [7:0] CharCr    = 8'h0d;
	localparam logic [7:0] CharLf    = 8'h0a;
	localparam logic [7:0] CharDash  = 8'h2d;
	localparam logic [7:0] CharQuote = 8'h22;
	localparam logic [7:0] CharF     = 8'h66;

	localparam logic [PrefixLen*8-1:0] PrefixText = "Content-Disposition: form-data;";
	localparam logic [NeedleLen*8-1:0] NeedleText = "filename=\"";

	// control from the top level into every window cell
	typedef struct packed {
		logic       shift;
		logic       write;
		logic [5:0] wr_pos;
		logic       clear;
	} cell_ctl_t;

	function automatic logic [7:0] prefix_char(input logic [5:0] i);
		logic [4:0] j;
		j = 5'(PrefixLen - 1 - int'(i));
		return PrefixText[j*8 +: 8];
	endfunction

	function automatic logic [7:0] needle_char(input logic [3:0] i);
		logic [3:0] j;
		j = 4'(NeedleLen - 1 - int'(i));
		return NeedleText[j*8 +: 8];
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
	endfunction

endpackage

/* src/mfd_if.sv */
// ----------------------------------------------------------------------------
// mfd_body_if / mfd_result_if
// valid/ready channels for body bytes and result words
// ----------------------------------------------------------------------------
interface mfd_body_if;
	logic       valid;
	logic       ready;
	logic [7:0] body_byte;
	logic       end_of_body;
	modport source (output valid, body_byte, end_of_body, input ready);
	modport sink (input valid, body_byte, end_of_body, output ready);
endinterface

interface mfd_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] result_kind;
	logic [7:0] result_byte;
	modport source (output valid, result_kind, result_byte, input ready);
	modport sink (input valid, result_kind, result_byte, output ready);
endinterface

/* src/mfd_cell.sv */
// ----------------------------------------------------------------------------
// mfd_cell
// one delimiter window slot: holds a byte, shifts toward slot 0, compares
// ----------------------------------------------------------------------------
module mfd_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [5:0]        pos,
	input  mfd_pkg::cell_ctl_t ctl,
	input  logic [7:0]        in_byte,
	input  logic [7:0]        next_byte,
	input  logic [7:0]        expect_byte,
	output logic [7:0]        data,
	output logic              hit
);

	logic [7:0] data_q;

	// the written byte lands at wr_pos; with a shift, slot wr_pos-1 takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (ctl.clear) begin
			data_q <= '0;
		end else if (ctl.shift) begin
			data_q <= (ctl.write && ctl.wr_pos == pos + 6'd1) ? in_byte : next_byte;
		end else if (ctl.write && ctl.wr_pos == pos) begin
			data_q <= in_byte;
		end
	end

	assign data = data_q;
	assign hit  = (data_q == expect_byte);

endmodule

/* src/mfd_window.sv */
// ----------------------------------------------------------------------------
// mfd_window
// row of window cells with a combinational delimiter compare
// ----------------------------------------------------------------------------
module mfd_window (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mfd_pkg::cell_ctl_t                ctl,
	input  logic [7:0]                        in_byte,
	input  logic [mfd_pkg::WinDepth*8-1:0]    expect_bytes,
	output logic [mfd_pkg::WinDepth*8-1:0]    bytes,
	output logic [mfd_pkg::WinDepth-1:0]      hits
);

	for (genvar g = 0; g < mfd_pkg::WinDepth; g++) begin : g_cell
		logic [7:0] nxt;
		if (g == mfd_pkg::WinDepth - 1) begin : g_last
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = bytes[(g+1)*8 +: 8];
		end
		mfd_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.pos        (6'(g)),
			.ctl        (ctl),
			.in_byte    (in_byte),
			.next_byte  (nxt),
			.expect_byte(expect_bytes[g*8 +: 8]),
			.data       (bytes[g*8 +: 8]),
			.hit        (hits[g])
		);
	end

endmodule

/* src/multipart_form_deframer_unit.sv */
// ----------------------------------------------------------------------------
// multipart_form_deframer_unit
// multipart/form-data body deframer: filename and file bytes out
// ----------------------------------------------------------------------------
// channel  dir  handshake      payload
// body     in   valid/ready    body_byte, end_of_body
// result   out  valid/ready    result_kind, result_byte
// apb      in   psel/penable   paddr, pwdata (64 bits), prdata
//
// one byte per cycle unless stalled; all window slots compare in parallel
// the result register takes a new word each cycle it is empty or being taken
// arst_n clears control and the window; registers reset to length 1, words 0
// a stalled result blocks body only while the output register stays full
// ----------------------------------------------------------------------------
module multipart_form_deframer_unit (
	input  logic               clk,
	input  logic               arst_n,
	mfd_body_if.sink           body,
	mfd_result_if.source       result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready
);

	localparam int W = mfd_pkg::WinDepth;

	// configuration
	logic [5:0]  len_reg_q;
	logic [63:0] word_q [7];

	logic [2:0] cfg_idx;
	assign cfg_idx = paddr[5:3];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_reg_q <= 6'd1;
			for (int i = 0; i < 7; i++) word_q[i] <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (mfd_pkg::reg_idx_t'(cfg_idx))
				mfd_pkg::REG_LENGTH: len_reg_q <= pwdata[5:0];
				mfd_pkg::REG_WORD0:  word_q[0] <= pwdata;
				mfd_pkg::REG_WORD1:  word_q[1] <= pwdata;
				mfd_pkg::REG_WORD2:  word_q[2] <= pwdata;
				mfd_pkg::REG_WORD3:  word_q[3] <= pwdata;
				mfd_pkg::REG_WORD4:  word_q[4] <= pwdata;
				mfd_pkg::REG_WORD5:  word_q[5] <= pwdata;
				mfd_pkg::REG_WORD6:  word_q[6] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (mfd_pkg::reg_idx_t'(cfg_idx))
			mfd_pkg::REG_LENGTH: prdata = {58'd0, len_reg_q};
			mfd_pkg::REG_WORD0:  prdata = word_q[0];
			mfd_pkg::REG_WORD1:  prdata = word_q[1];
			mfd_pkg::REG_WORD2:  prdata = word_q[2];
			mfd_pkg::REG_WORD3:  prdata = word_q[3];
			mfd_pkg::REG_WORD4:  prdata = word_q[4];
			mfd_pkg::REG_WORD5:  prdata = word_q[5];
			mfd_pkg::REG_WORD6:  prdata = word_q[6];
			default:             prdata = '0;
		endcase
	end

	logic [5:0] len;
	always_comb begin
		if (len_reg_q == 6'd0) len = 6'd1;
		else if (len_reg_q > 6'(mfd_pkg::MaxBoundary)) len = 6'(mfd_pkg::MaxBoundary);
		else len = len_reg_q;
	end

	logic [mfd_pkg::MaxBoundary*8-1:0] bnd;
	assign bnd = {word_q[6], word_q[5], word_q[4], word_q[3], word_q[2], word_q[1], word_q[0]};

	// state
	mfd_pkg::phase_t phase_q, phase_d;
	logic [5:0] open_pos_q, open_pos_d;
	logic [mfd_pkg::FillW-1:0] fill_q, fill_d;
	logic [5:0] pre_pos_q, pre_pos_d;
	logic [3:0] ndl_pos_q, ndl_pos_d;
	logic pre_ok_q, pre_ok_d, cap_q, cap_d, seen_q, seen_d;
	logic empty_q, empty_d, cr_q, cr_d;

	logic       res_valid_q;
	logic [2:0] res_kind_q;
	logic [7:0] res_byte_q;

	logic fire, emit;
	logic [2:0] kind;
	logic [7:0] obyte;
	mfd_pkg::cell_ctl_t ctl;

	assign body.ready = !res_valid_q || result.ready;
	assign fire       = body.valid && body.ready;

	logic [7:0] b;
	assign b = body.body_byte;

	// window: fill counts bytes, expected string aligned to the fill
	logic [W*8-1:0] win_bytes, win_exp;
	logic [W-1:0]   win_hit;
	logic [6:0]     m;
	assign m = 7'(len) + 7'd4;

	logic [mfd_pkg::FillW-1:0] fill_w;
	assign fill_w = (fill_q < mfd_pkg::FillW'(W)) ? fill_q + 1'b1 : fill_q;

	// slot k compares with delimiter char k - (fill_w - m)
	always_comb begin
		for (int k = 0; k < W; k++) begin
			logic [6:0] d;
			d = 7'(k) - (7'(fill_w) - m);
			if (d == 7'd0) win_exp[k*8 +: 8] = mfd_pkg::CharCr;
			else if (d == 7'd1) win_exp[k*8 +: 8] = mfd_pkg::CharLf;
			else if (d < 7'd4) win_exp[k*8 +: 8] = mfd_pkg::CharDash;
			else if (d < m) win_exp[k*8 +: 8] = bnd[6'(d - 7'd4)*8 +: 8];
			else win_exp[k*8 +: 8] = 8'h00;
		end
	end

	// newest byte compares with the delimiter's last character
	logic [7:0] last_exp;
	assign last_exp = bnd[6'(len - 6'd1)*8 +: 8];

	logic match;
	always_comb begin
		match = (b == last_exp) && (7'(fill_w) >= m);
		for (int k = 0; k < W; k++) begin
			if (7'(k) + m >= 7'(fill_w) && 7'(k) < 7'(fill_w) - 7'd1 &&
			    !win_hit[k]) match = 1'b0;
		end
	end

	// next state
	always_comb begin
		logic [5:0] p;
		logic [7:0] oc;
		logic       handled;
		logic       hc;
		logic [7:0] c;
		phase_d = phase_q; open_pos_d = open_pos_q; fill_d = fill_q;
		pre_pos_d = pre_pos_q; ndl_pos_d = ndl_pos_q; pre_ok_d = pre_ok_q;
		cap_d = cap_q; seen_d = seen_q; empty_d = empty_q; cr_d = cr_q;
		emit = 1'b0; kind = mfd_pkg::KIND_FILE_BYTE; obyte = 8'h00;
		ctl = '0; handled = 1'b0; hc = 1'b0; c = b;
		p = (open_pos_q > len + 6'd3) ? len + 6'd3 : open_pos_q;
		if (p < 6'd2) oc = mfd_pkg::CharDash;
		else if (p < len + 6'd2) oc = bnd[6'(p - 6'd2)*8 +: 8];
		else if (p == len + 6'd2) oc = mfd_pkg::CharCr;
		else oc = mfd_pkg::CharLf;
		if (fire) begin
			unique case (phase_q)
				mfd_pkg::PH_OPEN: begin
					if (b == oc) begin
						if (p == len + 6'd3) begin
							phase_d = mfd_pkg::PH_HEAD;
							pre_pos_d = '0; pre_ok_d = 1'b0; ndl_pos_d = '0;
							cap_d = 1'b0; empty_d = 1'b1; cr_d = 1'b0;
						end else open_pos_d = p + 6'd1;
					end else begin
						phase_d = mfd_pkg::PH_FAIL;
						emit = 1'b1; kind = mfd_pkg::KIND_BAD_OPEN;
					end
				end
				mfd_pkg::PH_HEAD: begin
					if (cr_q) begin
						cr_d = 1'b0;
						if (b == mfd_pkg::CharLf) begin
							handled = 1'b1;
							if (empty_q) begin
								phase_d = mfd_pkg::PH_DATA; fill_d = '0;
							end else begin
								pre_pos_d = '0; pre_ok_d = 1'b0; ndl_pos_d = '0;
								cap_d = 1'b0; empty_d = 1'b1;
							end
						end else if (!cap_q) begin
							// lone CR is line content; it cannot emit here
							empty_d = 1'b0;
							if (!seen_q) begin
								if (!pre_ok_q) begin
									if (pre_pos_q < 6'(mfd_pkg::PrefixLen) &&
									    mfd_pkg::to_lower(mfd_pkg::CharCr) ==
									    mfd_pkg::to_lower(mfd_pkg::prefix_char(pre_pos_q))) begin
										pre_pos_d = pre_pos_q + 6'd1;
									end else pre_pos_d = 6'(mfd_pkg::PrefixDead);
								end else ndl_pos_d = '0;
							end
						end else empty_d = 1'b0;
					end
					if (!handled) begin
						if (b == mfd_pkg::CharCr) cr_d = 1'b1;
						else hc = 1'b1;
					end
					if (hc) begin
						empty_d = 1'b0;
						if (!seen_q) begin
							if (cap_q) begin
								emit = 1'b1;
								if (c == mfd_pkg::CharQuote) begin
									cap_d = 1'b0; seen_d = 1'b1;
									kind = mfd_pkg::KIND_NAME_DONE;
								end else begin
									kind = mfd_pkg::KIND_NAME_CHAR; obyte = c;
								end
							end else if (!pre_ok_d) begin
								if (pre_pos_d < 6'(mfd_pkg::PrefixLen) &&
								    mfd_pkg::to_lower(c) ==
								    mfd_pkg::to_lower(mfd_pkg::prefix_char(pre_pos_d))) begin
									pre_pos_d = pre_pos_d + 6'd1;
									if (pre_pos_d == 6'(mfd_pkg::PrefixLen)) pre_ok_d = 1'b1;
								end else pre_pos_d = 6'(mfd_pkg::PrefixDead);
							end else if (ndl_pos_d < 4'(mfd_pkg::NeedleLen) &&
							             c == mfd_pkg::needle_char(ndl_pos_d)) begin
								ndl_pos_d = ndl_pos_d + 4'd1;
								if (ndl_pos_d == 4'(mfd_pkg::NeedleLen)) begin
									cap_d = 1'b1; ndl_pos_d = '0;
								end
							end else ndl_pos_d = (c == mfd_pkg::CharF) ? 4'd1 : 4'd0;
						end
					end
				end
				mfd_pkg::PH_DATA: begin
					ctl.write  = (fill_q < mfd_pkg::FillW'(W));
					ctl.wr_pos = 6'(fill_q);
					fill_d     = fill_w;
					if (7'(fill_w) >= m) begin
						emit = 1'b1;
						if (match) begin
							phase_d = mfd_pkg::PH_DONE; fill_d = '0;
							kind = mfd_pkg::KIND_UPLOAD_END;
						end else begin
							kind = mfd_pkg::KIND_FILE_BYTE;
							obyte = (fill_q == '0) ? b : win_bytes[7:0];
							ctl.shift = 1'b1;
							fill_d = fill_w - 1'b1;
						end
					end
				end
				default: ;
			endcase
			if (body.end_of_body) begin
				phase_d = mfd_pkg::PH_OPEN; open_pos_d = '0; fill_d = '0;
				seen_d = 1'b0; pre_pos_d = '0; pre_ok_d = 1'b0; ndl_pos_d = '0;
				cap_d = 1'b0; empty_d = 1'b1; cr_d = 1'b0; ctl.clear = 1'b1;
			end
		end
	end

	mfd_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.in_byte     (b),
		.expect_bytes(win_exp),
		.bytes       (win_bytes),
		.hits        (win_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mfd_pkg::PH_OPEN; open_pos_q <= '0; fill_q <= '0;
			pre_pos_q <= '0; ndl_pos_q <= '0; pre_ok_q <= 1'b0; cap_q <= 1'b0;
			seen_q <= 1'b0; empty_q <= 1'b1; cr_q <= 1'b0; res_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d; open_pos_q <= open_pos_d; fill_q <= fill_d;
			pre_pos_q <= pre_pos_d; ndl_pos_q <= ndl_pos_d; pre_ok_q <= pre_ok_d;
			cap_q <= cap_d; seen_q <= seen_d; empty_q <= empty_d; cr_q <= cr_d;
			if (fire) res_valid_q <= emit;
			else if (result.ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			res_kind_q <= kind;
			res_byte_q <= obyte;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.result_kind = res_kind_q;
	assign result.result_byte = res_byte_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= mfd_pkg::FillW'(W)) else $error("window fill overrun");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !result.ready |-> !fire) else $error("accepted into full output");
	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == mfd_pkg::PH_DONE && fire |=> !res_valid_q)
		else $error("result after upload end");
	a_data_only_fill: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != mfd_pkg::PH_DATA |-> fill_q == '0) else $error("fill outside data");

endmodule

/* bench/mfd_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mfd_checker
// watches body, result and register port of the deframer, predicts every
// result word from the accepted body bytes and compares it field by field
// ----------------------------------------------------------------------------
module mfd_checker (
	input  logic        clk,
	input  logic        arst_n,
	mfd_body_if         body,
	mfd_result_if       result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	input  logic        pready,
	output int          fails,
	output int          pending
);

	typedef struct packed {
		mfd_pkg::kind_t kind;
		logic [7:0]     data;
	} word_t;

	word_t expected_words[$];

	// register copy
	logic [5:0]  bnd_len;
	logic [63:0] bnd_word[7];

	// parser copy
	mfd_pkg::phase_t ph;
	int         open_pos, fill, pfx_pos, ndl_pos;
	logic       pfx_hit, capturing, name_seen, line_empty, saw_cr;
	logic [7:0] window[mfd_pkg::WinDepth];

	string pfx_str = "Content-Disposition: form-data;";
	string ndl_str = "filename=\"";

	function automatic int eff_len();
		if (bnd_len < 1) return 1;
		if (bnd_len > mfd_pkg::MaxBoundary) return mfd_pkg::MaxBoundary;
		return int'(bnd_len);
	endfunction

	function automatic logic [7:0] bnd_char(input int i);
		if (i >= mfd_pkg::MaxBoundary) return 8'h00;
		return bnd_word[i / 8][(i % 8) * 8 +: 8];
	endfunction

	function automatic logic [7:0] delim_char(input int k);
		if (k == 0) return mfd_pkg::CharCr;
		if (k == 1) return mfd_pkg::CharLf;
		if (k < 4) return mfd_pkg::CharDash;
		return bnd_char(k - 4);
	endfunction

	function automatic logic [7:0] open_char(input int p, input int n);
		if (p < 2) return mfd_pkg::CharDash;
		if (p < n + 2) return bnd_char(p - 2);
		if (p == n + 2) return mfd_pkg::CharCr;
		return mfd_pkg::CharLf;
	endfunction

	function automatic logic [7:0] fold(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic void new_line();
		pfx_pos    = 0;
		pfx_hit    = 1'b0;
		ndl_pos    = 0;
		capturing  = 1'b0;
		line_empty = 1'b1;
		saw_cr     = 1'b0;
	endfunction

	function automatic void clear_parser();
		ph        = mfd_pkg::PH_OPEN;
		open_pos  = 0;
		fill      = 0;
		name_seen = 1'b0;
		foreach (window[i]) window[i] = 8'h00;
		new_line();
	endfunction

	// one byte of header line content
	function automatic void header_byte(input logic [7:0] c, input logic emit);
		line_empty = 1'b0;
		if (name_seen) return;
		if (capturing) begin
			if (c == mfd_pkg::CharQuote) begin
				capturing = 1'b0;
				name_seen = 1'b1;
				if (emit) expected_words.push_back({mfd_pkg::KIND_NAME_DONE, 8'h00});
			end else if (emit) begin
				expected_words.push_back({mfd_pkg::KIND_NAME_CHAR, c});
			end
			return;
		end
		if (!pfx_hit) begin
			if (pfx_pos < mfd_pkg::PrefixLen && fold(c) == fold(pfx_str[pfx_pos])) begin
				pfx_pos++;
				if (pfx_pos == mfd_pkg::PrefixLen) pfx_hit = 1'b1;
			end else begin
				pfx_pos = mfd_pkg::PrefixDead;
			end
			return;
		end
		if (ndl_pos < mfd_pkg::NeedleLen && c == ndl_str[ndl_pos]) begin
			ndl_pos++;
			if (ndl_pos == mfd_pkg::NeedleLen) begin
				capturing = 1'b1;
				ndl_pos   = 0;
			end
		end else begin
			ndl_pos = (c == mfd_pkg::CharF) ? 1 : 0;
		end
	endfunction

	function automatic void take_byte(input logic [7:0] b, input logic eob);
		int   n, p, m, base;
		logic hit, done;
		n    = eff_len();
		done = 1'b0;
		case (ph)
			mfd_pkg::PH_OPEN: begin
				p = (open_pos > n + 3) ? n + 3 : open_pos;
				if (b == open_char(p, n)) begin
					if (p == n + 3) begin
						ph = mfd_pkg::PH_HEAD;
						new_line();
					end else begin
						open_pos = p + 1;
					end
				end else begin
					ph = mfd_pkg::PH_FAIL;
					expected_words.push_back({mfd_pkg::KIND_BAD_OPEN, 8'h00});
				end
			end
			mfd_pkg::PH_HEAD: begin
				if (saw_cr) begin
					saw_cr = 1'b0;
					if (b == mfd_pkg::CharLf) begin
						if (line_empty) begin
							ph   = mfd_pkg::PH_DATA;
							fill = 0;
						end else begin
							new_line();
						end
						done = 1'b1;
					end else if (!capturing) begin
						header_byte(mfd_pkg::CharCr, 1'b0);
					end else begin
						line_empty = 1'b0;
					end
				end
				if (!done) begin
					if (b == mfd_pkg::CharCr) saw_cr = 1'b1;
					else header_byte(b, 1'b1);
				end
			end
			mfd_pkg::PH_DATA: begin
				m = n + 4;
				if (fill < mfd_pkg::WinDepth) begin
					window[fill] = b;
					fill++;
				end
				if (fill >= m) begin
					base = fill - m;
					hit  = 1'b1;
					for (int k = 0; k < m; k++)
						if (window[base + k] != delim_char(k)) hit = 1'b0;
					if (hit) begin
						ph   = mfd_pkg::PH_DONE;
						fill = 0;
						expected_words.push_back({mfd_pkg::KIND_UPLOAD_END, 8'h00});
					end else begin
						expected_words.push_back({mfd_pkg::KIND_FILE_BYTE, window[0]});
						for (int k = 0; k < mfd_pkg::WinDepth - 1; k++)
							window[k] = window[k + 1];
						window[mfd_pkg::WinDepth - 1] = 8'h00;
						fill--;
					end
				end
			end
			default: ;
		endcase
		if (eob) clear_parser();
	endfunction

	task automatic report(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		word_t w;
		if (!arst_n) begin
			fails   = 0;
			bnd_len = 6'd1;
			foreach (bnd_word[i]) bnd_word[i] = '0;
			expected_words.delete();
			clear_parser();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (mfd_pkg::reg_idx_t'(paddr[5:3]))
					mfd_pkg::REG_LENGTH: bnd_len = pwdata[5:0];
					default: bnd_word[paddr[5:3] - 1] = pwdata;
				endcase
			end
			if (body.valid && body.ready) take_byte(body.body_byte, body.end_of_body);
			if (result.valid && result.ready) begin
				if (expected_words.size() == 0) begin
					report($sformatf("unexpected word kind %0d byte %02h",
						result.result_kind, result.result_byte));
				end else begin
					w = expected_words.pop_front();
					if (result.result_kind != w.kind)
						report($sformatf("kind %0d, want %0d", result.result_kind, w.kind));
					if (result.result_byte != w.data)
						report($sformatf("byte %02h, want %02h", result.result_byte, w.data));
				end
			end
		end
		pending = expected_words.size();
	end

	final begin
	end

endmodule

/* bench/tb_multipart_form_deframer_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multipart_form_deframer_unit
// feeds whole multipart bodies (good, broken, odd headers) under several
// boundary settings and idle patterns; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_multipart_form_deframer_unit;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata, prdata;
	logic        pready;
	int          fails, pending;
	int          send_idle, recv_stall;

	logic [5:0]  cur_len;
	logic [63:0] cur_words[7];
	logic [7:0]  body_bytes[$];
	int          cfg_count;

	mfd_body_if   body ();
	mfd_result_if result ();

	multipart_form_deframer_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.body    (body),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	mfd_checker i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.body    (body),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.pready  (pready),
		.fails   (fails),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3ms;
		$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) result.ready <= ($urandom_range(99) >= recv_stall);

	function automatic int eff_len();
		if (cur_len < 1) return 1;
		if (cur_len > mfd_pkg::MaxBoundary) return mfd_pkg::MaxBoundary;
		return int'(cur_len);
	endfunction

	task automatic apb_write(input mfd_pkg::reg_idx_t idx, input logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// wait until nothing is owed, then let words still in flight drain
	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_boundary(input logic [5:0] len);
		body.valid <= 1'b0;
		drain();
		cur_len = len;
		apb_write(mfd_pkg::REG_LENGTH, {58'd0, len});
		for (int i = 0; i < 7; i++) begin
			cur_words[i] = {$urandom, $urandom};
			apb_write(mfd_pkg::reg_idx_t'(i + 1), cur_words[i]);
		end
	endtask

	task automatic next_boundary();
		logic [5:0] len;
		case (cfg_count)
			0: len = 6'd1;
			1: len = 6'd56;
			2: len = 6'd0;
			3: len = 6'd63;
			default: len = ($urandom_range(9) == 0) ? 6'($urandom_range(56, 20))
				: 6'($urandom_range(8, 1));
		endcase
		cfg_count++;
		set_boundary(len);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic eob);
		if ($urandom_range(99) < send_idle) begin
			body.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle) @(posedge clk);
		end
		body.valid       <= 1'b1;
		body.body_byte   <= b;
		body.end_of_body <= eob;
		@(posedge clk);
		while (!body.ready) @(posedge clk);
	endtask

	task automatic send_body();
		foreach (body_bytes[i]) send_byte(body_bytes[i], i == body_bytes.size() - 1);
		body_bytes.delete();
	endtask

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++) body_bytes.push_back(s[i]);
	endtask

	task automatic push_delim(input logic with_crlf);
		if (with_crlf) push_str("\r\n");
		push_str("--");
		for (int i = 0; i < eff_len(); i++) body_bytes.push_back(cur_words[i / 8][(i % 8) * 8 +: 8]);
	endtask

	task automatic push_random(input int n);
		repeat (n) body_bytes.push_back(8'($urandom_range(255)));
	endtask

	// a body with random content; mostly well formed, some broken on purpose
	task automatic make_body();
		int    pick, n;
		string pfx;
		pfx = "Content-Disposition: form-data;";
		push_delim(1'b0);
		push_str("\r\n");
		if ($urandom_range(9) == 0)
			body_bytes[$urandom_range(body_bytes.size() - 1)] = 8'($urandom_range(255));
		repeat ($urandom_range(2)) begin
			n = $urandom_range(6);
			repeat (n) body_bytes.push_back(8'($urandom_range(126, 32)));
			if ($urandom_range(3) == 0) push_str("\r");
			push_str("x\r\n");
		end
		pick = $urandom_range(9);
		if (pick != 0) begin
			// prefix with mixed letter case
			for (int i = 0; i < pfx.len(); i++)
				if (pfx[i] >= "a" && pfx[i] <= "z" && $urandom_range(3) == 0)
					body_bytes.push_back(pfx[i] - 8'd32);
				else
					body_bytes.push_back(pfx[i]);
			push_str(" name=\"up\"; ff");
			push_str("filename=\"");
			n = (pick == 1) ? 0 : $urandom_range(6);
			for (int i = 0; i < n; i++)
				if ($urandom_range(7) == 0) push_str("\r");
				else body_bytes.push_back(8'($urandom_range(126, 35)));
			if (pick != 2) push_str("\"");
			push_str("\r\n");
			if (pick == 3) push_str("content-disposition: form-data; filename=\"b\"\r\n");
		end
		if ($urandom_range(12) != 0) begin
			push_str("\r\n");
			n = $urandom_range(24);
			for (int i = 0; i < n; i++)
				if ($urandom_range(9) == 0) push_str("\r\n-");
				else body_bytes.push_back(8'($urandom_range(255)));
			if ($urandom_range(9) != 0) push_delim(1'b1);
			push_random($urandom_range(3));
		end
	endtask

	initial begin
		int phase_bytes;
		int bodies;
		body.valid       = 1'b0;
		body.body_byte   = 8'h00;
		body.end_of_body = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		send_idle  = 0;
		recv_stall = 0;
		cfg_count  = 0;
		cur_len    = 6'd1;
		foreach (cur_words[i]) cur_words[i] = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: bad first byte, bad byte late in opening, tiny full upload
		set_boundary(6'd3);
		body_bytes.push_back(8'hff);
		body_bytes.push_back(8'h00);
		send_body();
		push_str("--");
		body_bytes.push_back(cur_words[0][7:0]);
		push_str("\n\r");
		send_body();
		push_delim(1'b0);
		push_str("\r\nContent-Disposition: form-data; filename=\"\"\r\n\r\n");
		body_bytes.push_back(8'h00);
		body_bytes.push_back(8'h80);
		push_delim(1'b1);
		push_str("z");
		send_body();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 55; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 55; end
				default: begin send_idle = 33; recv_stall = 33; end
			endcase
			phase_bytes = 0;
			bodies      = 0;
			while (phase_bytes < 160) begin
				if (bodies % 3 == 0) next_boundary();
				make_body();
				phase_bytes += body_bytes.size();
				send_body();
				bodies++;
				if (ph == 1 && bodies == 1) begin
					body.valid <= 1'b0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
			end
		end
		body.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* multipart_form_deframer_unit.f */
src/mfd_pkg.sv
src/mfd_if.sv
src/mfd_cell.sv
src/mfd_window.sv
src/multipart_form_deframer_unit.sv
bench/mfd_checker.sv
bench/tb_multipart_form_deframer_unit.sv
